>>> rtl/core/single_to_half_convert_top_macros.svh
// Assertion macros shared by the single-to-half decode, pack and top modules.
`ifndef SINGLE_TO_HALF_CONVERT_TOP_MACROS_SVH
`define SINGLE_TO_HALF_CONVERT_TOP_MACROS_SVH

// Plain property, clocked on clk_i and disabled while rst_ni is low.
`define S2H_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define S2H_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define S2H_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/s2h_pkg.sv
// Shared types and constants for the single-to-half precision converter.
`timescale 1ns / 1ps

package s2h_pkg;

  // Field widths of the two formats.
  localparam int unsigned SglW      = 32;
  localparam int unsigned SglExpW   = 8;
  localparam int unsigned SglMantW  = 23;
  localparam int unsigned HalfW     = 16;
  localparam int unsigned HalfExpW  = 5;
  localparam int unsigned HalfMantW = 10;
  localparam int unsigned ShamtW    = 4;

  // Exponent field thresholds of the single input.
  localparam logic [SglExpW-1:0] EXP_SPECIAL  = 8'hFF;
  localparam logic [SglExpW-1:0] EXP_OVF      = 8'd143;
  localparam logic [SglExpW-1:0] EXP_NORM_MIN = 8'd113;
  localparam logic [SglExpW-1:0] EXP_SUB_MIN  = 8'd102;
  localparam logic [SglExpW-1:0] REBIAS       = 8'd112;

  // Half-precision patterns without the sign.
  localparam logic [HalfW-2:0]     HALF_INF  = 15'h7C00;
  localparam logic [HalfMantW-1:0] HALF_QNAN = 10'h200;
  localparam logic [HalfExpW-1:0]  HALF_EXP_ALL_ONES = 5'h1F;

  // Result class decided at decode time.
  typedef enum logic [1:0] {
    CLS_FINITE,
    CLS_ZERO,
    CLS_INF,
    CLS_NAN
  } cls_e;

  // Decode stage payload.
  typedef struct packed {
    logic                  sign;
    cls_e                  cls;
    logic [HalfExpW-1:0]   exp;
    logic [ShamtW-1:0]     shamt;
    logic [SglMantW-1:0]   mant;
  } dec_t;

  // Shift stage payload: the aligned significand ready for rounding.
  typedef struct packed {
    logic                  sign;
    cls_e                  cls;
    logic [HalfExpW-1:0]   exp;
    logic [SglMantW-1:0]   sig;
  } sig_t;

endpackage

>>> rtl/core/s2h_decode.sv
// Stage one: classifies the single input and rebiases its exponent.
`timescale 1ns / 1ps

`include "single_to_half_convert_top_macros.svh"

module s2h_decode (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [s2h_pkg::SglW-1:0]      single_bits_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output s2h_pkg::dec_t                 out_o
);

  logic                            valid_q;
  logic                            load;
  logic [s2h_pkg::SglExpW-1:0]     exp_fld;
  logic [s2h_pkg::SglMantW-1:0]    mant;
  logic [s2h_pkg::SglExpW-1:0]     exp_reb;
  logic [s2h_pkg::SglExpW-1:0]     sub_sh;
  s2h_pkg::dec_t                   dec_d;
  s2h_pkg::dec_t                   dec_q;

  // The stage takes a transaction when it is empty or drains this cycle.
  assign in_ready_o  = !valid_q || out_ready_i;
  assign load        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_o       = dec_q;

  // Classify by exponent range; subnormal results get a right shift.
  always_comb begin
    exp_fld = single_bits_i[s2h_pkg::SglW-2:s2h_pkg::SglMantW];
    mant    = single_bits_i[s2h_pkg::SglMantW-1:0];
    exp_reb = exp_fld - s2h_pkg::REBIAS;
    sub_sh  = s2h_pkg::EXP_NORM_MIN - exp_fld;

    dec_d       = '0;
    dec_d.sign  = single_bits_i[s2h_pkg::SglW-1];
    dec_d.mant  = mant;
    dec_d.cls   = s2h_pkg::CLS_ZERO;
    if (exp_fld == s2h_pkg::EXP_SPECIAL) begin
      dec_d.cls = (mant != '0) ? s2h_pkg::CLS_NAN : s2h_pkg::CLS_INF;
    end else if (exp_fld >= s2h_pkg::EXP_OVF) begin
      dec_d.cls = s2h_pkg::CLS_INF;
    end else if (exp_fld >= s2h_pkg::EXP_NORM_MIN) begin
      dec_d.cls = s2h_pkg::CLS_FINITE;
      dec_d.exp = exp_reb[s2h_pkg::HalfExpW-1:0];
    end else if (exp_fld >= s2h_pkg::EXP_SUB_MIN) begin
      dec_d.cls   = s2h_pkg::CLS_FINITE;
      dec_d.shamt = sub_sh[s2h_pkg::ShamtW-1:0];
    end
  end

  // Valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      dec_q <= dec_d;
    end
  end

  // A subnormal result always needs a shift of one to eleven places.
  `S2H_ASSERT_IMPL(a_sub_shamt, valid_q && dec_q.cls == s2h_pkg::CLS_FINITE && dec_q.exp == '0, dec_q.shamt >= 4'd1 && dec_q.shamt <= 4'd11, "subnormal shift out of range")

endmodule

>>> rtl/core/s2h_shift.sv
// Stage two: aligns the significand for subnormal results.
`timescale 1ns / 1ps

module s2h_shift (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  s2h_pkg::dec_t   in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output s2h_pkg::sig_t   out_o
);

  logic                          valid_q;
  logic                          load;
  logic                          hidden;
  logic [s2h_pkg::SglMantW:0]    sig_full;
  s2h_pkg::sig_t                 sig_d;
  s2h_pkg::sig_t                 sig_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign load        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_o       = sig_q;

  // Subnormal results carry the hidden bit into the shifted significand.
  // Normal and special values pass with a shift of zero.
  always_comb begin
    hidden       = (in_i.exp == '0);
    sig_full     = {hidden, in_i.mant} >> in_i.shamt;
    sig_d.sign   = in_i.sign;
    sig_d.cls    = in_i.cls;
    sig_d.exp    = in_i.exp;
    sig_d.sig    = sig_full[s2h_pkg::SglMantW-1:0];
  end

  // Valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      sig_q <= sig_d;
    end
  end

endmodule

>>> rtl/core/s2h_pack.sv
// Stage three: rounds, packs the half pattern and holds the output register.
`timescale 1ns / 1ps

`include "single_to_half_convert_top_macros.svh"

module s2h_pack (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  s2h_pkg::sig_t               in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [s2h_pkg::HalfW-1:0]   half_bits_o
);

  localparam int unsigned DropW = s2h_pkg::SglMantW - s2h_pkg::HalfMantW;

  logic                              valid_q;
  logic                              load;
  logic [s2h_pkg::HalfMantW-1:0]     top;
  logic [s2h_pkg::HalfMantW:0]       rounded;
  logic [s2h_pkg::HalfW-2:0]         body;
  logic [s2h_pkg::HalfW-1:0]         half_d;
  logic [s2h_pkg::HalfW-1:0]         half_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign load        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign half_bits_o = half_q;

  // Round half up on the dropped bits. A carry out of the mantissa
  // lands in the exponent by the addition, which also turns the largest
  // finite range into infinity and the largest subnormal into a normal.
  always_comb begin
    top     = in_i.sig[s2h_pkg::SglMantW-1:DropW];
    rounded = {1'b0, top} + {{s2h_pkg::HalfMantW{1'b0}}, in_i.sig[DropW-1]};
    body    = {in_i.exp, {s2h_pkg::HalfMantW{1'b0}}}
            + {{(s2h_pkg::HalfExpW-1){1'b0}}, rounded};
    case (in_i.cls)
      s2h_pkg::CLS_FINITE: half_d = {in_i.sign, body};
      s2h_pkg::CLS_ZERO:   half_d = '0;
      s2h_pkg::CLS_INF:    half_d = {in_i.sign, s2h_pkg::HALF_INF};
      s2h_pkg::CLS_NAN: begin
        // Keep the top payload bits; force a quiet bit when they are all zero.
        half_d = {in_i.sign, s2h_pkg::HALF_EXP_ALL_ONES,
                  (top != '0) ? top : s2h_pkg::HALF_QNAN};
      end
      default:             half_d = '0;
    endcase
  end

  // Valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      half_q <= half_d;
    end
  end

  // A NaN stays a NaN, and underflow always gives plus zero.
  `S2H_ASSERT_NEXT(a_nan_kept, load && in_i.cls == s2h_pkg::CLS_NAN, half_q[14:10] == s2h_pkg::HALF_EXP_ALL_ONES && half_q[9:0] != '0, "NaN lost its payload")
  `S2H_ASSERT_NEXT(a_zero_plus, load && in_i.cls == s2h_pkg::CLS_ZERO, half_q == '0, "underflow did not give plus zero")

endmodule

>>> rtl/core/single_to_half_convert_top.sv
// Top level of the binary32 to binary16 converter pipeline.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         in_valid_i / in_ready_o   single_bits_i [31:0]
//   output    out        out_valid_o / out_ready_i half_bits_o   [15:0]
//
// A result passes the decode, shift and pack registers before it is offered.
// One transaction per cycle is sustained unless the output stalls; the three
// stages (decode, significand shift, round and pack) each hold one transaction.
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage takes a new transaction when it is empty or drains in the same
// cycle, so a stall at the output backs up stage by stage and nothing is lost.
`timescale 1ns / 1ps

`include "single_to_half_convert_top_macros.svh"

module single_to_half_convert_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [s2h_pkg::SglW-1:0]    single_bits_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [s2h_pkg::HalfW-1:0]   half_bits_o
);

  logic           dec_valid;
  logic           dec_ready;
  s2h_pkg::dec_t  dec;
  logic           sig_valid;
  logic           sig_ready;
  s2h_pkg::sig_t  sig;

  // Decode stage.
  s2h_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .single_bits_i (single_bits_i),
    .out_valid_o   (dec_valid),
    .out_ready_i   (dec_ready),
    .out_o         (dec)
  );

  // Shift stage.
  s2h_shift u_shift (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dec_valid),
    .in_ready_o  (dec_ready),
    .in_i        (dec),
    .out_valid_o (sig_valid),
    .out_ready_i (sig_ready),
    .out_o       (sig)
  );

  // Round and pack stage with the output register.
  s2h_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sig_valid),
    .in_ready_o  (sig_ready),
    .in_i        (sig),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .half_bits_o (half_bits_o)
  );

  // The input can only be held off when every stage is full and the
  // output is stalled.
  `S2H_ASSERT_IMPL(a_stall_source, !in_ready_o, out_valid_o && !out_ready_i && dec_valid && sig_valid, "input stalled without output backpressure")

endmodule
